// File: rtl/core/tra_pkg.sv
// Shared constants and width helpers for the rational tanh pipeline.
package tra_pkg;

  // Input sample and result word widths.
  localparam int XW     = 16;
  // Magnitude of the sample and its square.
  localparam int MAG_W  = 16;
  localparam int SQ_W   = 32;
  // Width of the clamp comparison (covers 4 << IN_FRAC_BITS up to 16 fraction bits).
  localparam int LIM_W  = 20;

  // Numerator polynomial coefficients.
  localparam int unsigned C_P0 = 135135;
  localparam int unsigned C_P1 = 17325;
  localparam int unsigned C_P2 = 378;
  // Denominator polynomial coefficients.
  localparam int unsigned C_Q0 = 135135;
  localparam int unsigned C_Q1 = 62370;
  localparam int unsigned C_Q2 = 3150;
  localparam int unsigned C_Q3 = 28;
  // Clamp threshold in whole units.
  localparam int unsigned C_LIM = 4;

  // Width of the scaled polynomials, rounded up to whole 32-bit chunks.
  function automatic int poly_width(int f);
    int ds;
    int w;
    ds = 2 * f;
    w  = 101;
    if (76 + ds > w) w = 76 + ds;
    if (48 + 2 * ds > w) w = 48 + 2 * ds;
    if (18 + 3 * ds > w) w = 18 + 3 * ds;
    w = w + 2;
    return ((w + 31) / 32) * 32;
  endfunction

endpackage

// File: rtl/core/tra_poly.sv
// Front stages: magnitude, powers of the square and both scaled polynomials.
module tra_poly #(
  parameter int IN_FRAC_BITS = 12,
  parameter int PW           = 128
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [tra_pkg::XW-1:0] x_in,
  output logic [tra_pkg::MAG_W-1:0]     mag,
  output logic                          neg,
  output logic                          clamp,
  output logic [PW-1:0]                 p,
  output logic [PW-1:0]                 q
);
  import tra_pkg::*;

  localparam int DS = 2 * IN_FRAC_BITS;
  localparam logic [LIM_W-1:0] LIM = LIM_W'(C_LIM) << IN_FRAC_BITS;

  logic [MAG_W-1:0]  mag_c;
  logic [MAG_W-1:0]  mag0, mag1, mag2, mag3;
  logic              neg0, neg1, neg2, neg3;
  logic              clamp0, clamp1, clamp2, clamp3;
  logic [SQ_W-1:0]   s0, s1, s2r, s3r;
  logic [2*SQ_W-1:0] sq2_1, sq2_2, sq2_3;
  logic [2*SQ_W-1:0] s3lo;
  logic [3*SQ_W-1:0] s3;

  assign mag_c = x_in[XW-1] ? MAG_W'(-x_in) : MAG_W'(x_in);

  always_ff @(posedge clk) begin
    if (en) begin
      // square the magnitude
      mag0   <= mag_c;
      neg0   <= x_in[XW-1];
      clamp0 <= LIM_W'(mag_c) > LIM;
      s0     <= SQ_W'(mag_c) * SQ_W'(mag_c);
      // fourth power
      mag1   <= mag0;
      neg1   <= neg0;
      clamp1 <= clamp0;
      s1     <= s0;
      sq2_1  <= (2*SQ_W)'(s0) * (2*SQ_W)'(s0);
      // sixth power, low half
      mag2   <= mag1;
      neg2   <= neg1;
      clamp2 <= clamp1;
      s2r    <= s1;
      sq2_2  <= sq2_1;
      s3lo   <= (2*SQ_W)'(sq2_1[SQ_W-1:0]) * (2*SQ_W)'(s1);
      // sixth power, high half
      mag3   <= mag2;
      neg3   <= neg2;
      clamp3 <= clamp2;
      s3r    <= s2r;
      sq2_3  <= sq2_2;
      s3     <= (3*SQ_W)'(s3lo)
              + ((3*SQ_W)'((2*SQ_W)'(sq2_2[2*SQ_W-1:SQ_W]) * (2*SQ_W)'(s2r)) << SQ_W);
      // polynomials
      mag    <= mag3;
      neg    <= neg3;
      clamp  <= clamp3;
      p      <= PW'(s3)
              + ((PW'(sq2_3) * PW'(C_P2)) << DS)
              + ((PW'(s3r) * PW'(C_P1)) << (2 * DS))
              + (PW'(C_P0) << (3 * DS));
      q      <= PW'(s3) * PW'(C_Q3)
              + ((PW'(sq2_3) * PW'(C_Q2)) << DS)
              + ((PW'(s3r) * PW'(C_Q1)) << (2 * DS))
              + (PW'(C_Q0) << (3 * DS));
    end
  end

endmodule

// File: rtl/core/tra_mac_cell.sv
// One cell of the numerator product chain: adds one 32-bit chunk of mag * P.
module tra_mac_cell #(
  parameter int PW            = 128,
  parameter int NW            = 162,
  parameter int J             = 0,
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [tra_pkg::MAG_W-1:0] mag_i,
  input  logic [PW-1:0]             p_i,
  input  logic [PW-1:0]             q_i,
  input  logic [NW-1:0]             acc_i,
  input  logic                      neg_i,
  input  logic                      clamp_i,
  output logic [tra_pkg::MAG_W-1:0] mag_o,
  output logic [PW-1:0]             p_o,
  output logic [PW-1:0]             q_o,
  output logic [NW-1:0]             acc_o,
  output logic                      neg_o,
  output logic                      clamp_o
);
  import tra_pkg::*;

  localparam int PPW = MAG_W + 32;

  logic [PPW-1:0] pp;

  assign pp = PPW'(mag_i) * PPW'(p_i[32*J +: 32]);

  always_ff @(posedge clk) begin
    if (en) begin
      mag_o   <= mag_i;
      p_o     <= p_i;
      q_o     <= q_i;
      neg_o   <= neg_i;
      clamp_o <= clamp_i;
      acc_o   <= acc_i + (NW'(pp) << (32 * J + OUT_FRAC_BITS + 1));
    end
  end

endmodule

// File: rtl/core/tra_div_cell.sv
// One restoring division cell: decides one quotient bit.
module tra_div_cell #(
  parameter int PW           = 128,
  parameter int NW           = 162,
  parameter int QW           = 16,
  parameter int IN_FRAC_BITS = 12,
  parameter int K            = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] rem_i,
  input  logic [PW-1:0] q_i,
  input  logic [QW-1:0] quo_i,
  input  logic          neg_i,
  input  logic          clamp_i,
  output logic [NW-1:0] rem_o,
  output logic [PW-1:0] q_o,
  output logic [QW-1:0] quo_o,
  output logic          neg_o,
  output logic          clamp_o
);
  logic [NW-1:0] t;
  logic          ge;

  assign t  = NW'(q_i) << (IN_FRAC_BITS + 1 + K);
  assign ge = rem_i >= t;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o   <= ge ? rem_i - t : rem_i;
      quo_o   <= quo_i | (QW'(ge) << K);
      q_o     <= q_i;
      neg_o   <= neg_i;
      clamp_o <= clamp_i;
    end
  end

endmodule

// File: rtl/core/tanh_rational_approximation.sv
// Top level: pipelined [7/6] rational tanh of a Q4.12 sample into Q2.14.
//
//   channel  | valid     | stall     | payload
//   ---------+-----------+-----------+------------------------
//   request  | in_valid  | in_stall  | x_in     (signed Q4.12)
//   result   | out_valid | out_stall | tanh_out (signed Q2.14)
//
// One request per cycle while in_stall is low. From acceptance to tanh_out a
// sample passes five polynomial stages, one product cell per 32-bit chunk
// of P, one division cell per quotient bit, then the output register.
// Reset clears only the valid flags. A result held by out_stall lets one more
// result drop into a skid register; in_stall rises only while that skid
// register is full.
module tanh_rational_approximation #(
  parameter int IN_FRAC_BITS  = 12,
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [tra_pkg::XW-1:0] x_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [tra_pkg::XW-1:0] tanh_out
);
  import tra_pkg::*;

  localparam int PW  = poly_width(IN_FRAC_BITS);
  localparam int NC  = PW / 32;
  localparam int NW  = PW + MAG_W + OUT_FRAC_BITS + 2;
  localparam int QW  = OUT_FRAC_BITS + 2;
  localparam int RW  = (QW > XW) ? QW : XW;
  localparam int NS  = 5 + NC + QW;

  logic          en;
  logic [NS-1:0] v;
  logic          skid_v;
  logic [XW-1:0] skid;

  // product chain wires
  logic [MAG_W-1:0] mc_mag   [NC+1];
  logic [PW-1:0]    mc_p     [NC+1];
  logic [PW-1:0]    mc_q     [NC+1];
  logic [NW-1:0]    mc_acc   [NC+1];
  logic             mc_neg   [NC+1];
  logic             mc_clamp [NC+1];

  // division chain wires
  logic [NW-1:0] dc_rem   [QW+1];
  logic [PW-1:0] dc_q     [QW+1];
  logic [QW-1:0] dc_quo   [QW+1];
  logic          dc_neg   [QW+1];
  logic          dc_clamp [QW+1];

  logic [RW-1:0] res_mag;
  logic [RW-1:0] res_signed;
  logic [XW-1:0] done_val;
  logic          done_v;

  // Advance the whole pipeline unless the skid register is occupied.
  assign en       = !skid_v;
  assign in_stall = skid_v;

  tra_poly #(
    .IN_FRAC_BITS(IN_FRAC_BITS),
    .PW          (PW)
  ) u_poly (
    .clk  (clk),
    .en   (en),
    .x_in (x_in),
    .mag  (mc_mag[0]),
    .neg  (mc_neg[0]),
    .clamp(mc_clamp[0]),
    .p    (mc_p[0]),
    .q    (mc_q[0])
  );

  // Seed the numerator with the rounding term Q * 2^F.
  assign mc_acc[0] = NW'(mc_q[0]) << IN_FRAC_BITS;

  for (genvar j = 0; j < NC; j++) begin : g_mac
    tra_mac_cell #(
      .PW           (PW),
      .NW           (NW),
      .J            (j),
      .OUT_FRAC_BITS(OUT_FRAC_BITS)
    ) u_cell (
      .clk    (clk),
      .en     (en),
      .mag_i  (mc_mag[j]),
      .p_i    (mc_p[j]),
      .q_i    (mc_q[j]),
      .acc_i  (mc_acc[j]),
      .neg_i  (mc_neg[j]),
      .clamp_i(mc_clamp[j]),
      .mag_o  (mc_mag[j+1]),
      .p_o    (mc_p[j+1]),
      .q_o    (mc_q[j+1]),
      .acc_o  (mc_acc[j+1]),
      .neg_o  (mc_neg[j+1]),
      .clamp_o(mc_clamp[j+1])
    );
  end

  assign dc_rem[0]   = mc_acc[NC];
  assign dc_q[0]     = mc_q[NC];
  assign dc_quo[0]   = '0;
  assign dc_neg[0]   = mc_neg[NC];
  assign dc_clamp[0] = mc_clamp[NC];

  // Quotient bits from the top one down.
  for (genvar i = 0; i < QW; i++) begin : g_div
    tra_div_cell #(
      .PW          (PW),
      .NW          (NW),
      .QW          (QW),
      .IN_FRAC_BITS(IN_FRAC_BITS),
      .K           (QW - 1 - i)
    ) u_cell (
      .clk    (clk),
      .en     (en),
      .rem_i  (dc_rem[i]),
      .q_i    (dc_q[i]),
      .quo_i  (dc_quo[i]),
      .neg_i  (dc_neg[i]),
      .clamp_i(dc_clamp[i]),
      .rem_o  (dc_rem[i+1]),
      .q_o    (dc_q[i+1]),
      .quo_o  (dc_quo[i+1]),
      .neg_o  (dc_neg[i+1]),
      .clamp_o(dc_clamp[i+1])
    );
  end

  // Apply the clamp and the sign, then keep the low 16 bits.
  assign res_mag    = dc_clamp[QW] ? (RW'(1) << OUT_FRAC_BITS) : RW'(dc_quo[QW]);
  assign res_signed = dc_neg[QW] ? -res_mag : res_mag;
  assign done_val   = res_signed[XW-1:0];
  assign done_v     = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else begin
      if (en) begin
        v <= {v[NS-2:0], in_valid};
      end
      if (!out_valid || !out_stall) begin
        // output register is free: drain the skid first
        if (skid_v) begin
          out_valid <= 1'b1;
          skid_v    <= 1'b0;
        end else begin
          out_valid <= done_v;
        end
      end else if (en && done_v) begin
        // output held: park the arriving result
        skid_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      tanh_out <= skid_v ? skid : done_val;
    end else if (en && done_v) begin
      skid <= done_val;
    end
  end

endmodule

// File: rtl/core/tra_checker.sv
// Port-level checks for the rational tanh block, bound to its top level.
module tra_checker #(
  parameter int OUT_FRAC_BITS = 14
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [tra_pkg::XW-1:0] tanh_out
);
  import tra_pkg::*;

  localparam logic signed [XW:0] ONE = (XW + 1)'(1) << ((OUT_FRAC_BITS > XW - 2) ?
                                                        (XW - 2) : OUT_FRAC_BITS);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tanh_out))
    else $error("stalled result dropped or changed");

  // Stall requests only while a result is waiting downstream.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("request stalled with no result waiting");

  // A stall needs the result side to have been stalled.
  a_stall_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("request stall without downstream stall");

  // Results stay within plus or minus one.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (OUT_FRAC_BITS > XW - 2) ||
                  ((XW + 1)'(tanh_out) <= ONE && (XW + 1)'(tanh_out) >= -ONE))
    else $error("result outside plus or minus one");

endmodule

bind tanh_rational_approximation tra_checker #(
  .OUT_FRAC_BITS(OUT_FRAC_BITS)
) u_tra_checker (
  .clk      (clk),
  .rst      (rst),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .tanh_out (tanh_out)
);

// File: dv/tanh_rational_approximation_checker.sv
// Checker for the rational tanh block: predicts each result and compares it.
module tanh_rational_approximation_checker #(
  parameter int IN_FRAC_BITS  = 12,
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [tra_pkg::XW-1:0] x_in,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [tra_pkg::XW-1:0] tanh_out,
  output int                            fail_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0] expected_tanh[$];

  // 256 bits covers the scaled polynomials at these fraction widths.
  function automatic logic [15:0] tanh_of(logic [15:0] x);
    logic [255:0] s, p, d, num, den, t, mag;
    logic [63:0] q;
    logic neg;
    int f;
    int k;
    f = IN_FRAC_BITS;
    neg = x[15];
    mag = neg ? 256'(17'h10000 - x) : 256'(x);
    q = 0;
    if (mag > (256'd4 << f)) begin
      q = 64'd1 << OUT_FRAC_BITS;
    end else begin
      s = mag * mag;
      p = (256'd378 << (2 * f)) + s;
      p = p * s + (256'd17325 << (4 * f));
      p = p * s + (256'd135135 << (6 * f));
      d = 256'd28 * s + (256'd3150 << (2 * f));
      d = d * s + (256'd62370 << (4 * f));
      d = d * s + (256'd135135 << (6 * f));
      num = ((p * mag) << (OUT_FRAC_BITS + 1)) + (d << f);
      den = d << (f + 1);
      for (k = OUT_FRAC_BITS + 1; k >= 0; k--) begin
        t = den << k;
        if (num >= t) begin
          num = num - t;
          q[k] = 1'b1;
        end
      end
    end
    return neg ? 16'(-q) : q[15:0];
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  initial fail_count = 0;
  initial pending = 0;

  always @(posedge clk) begin
    logic [15:0] want;
    if (!rst) begin
      if (in_valid && !in_stall) expected_tanh.push_back(tanh_of(x_in));
      if (out_valid && !out_stall) begin
        if (expected_tanh.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", tanh_out));
        end else begin
          want = expected_tanh.pop_front();
          if (tanh_out !== want)
            report_mismatch($sformatf("tanh_out %h, want %h", tanh_out, want));
        end
      end
    end
    pending = expected_tanh.size();
  end
endmodule

// File: dv/tb_tanh_rational_approximation.sv
// Testbench top: drives requests into the rational tanh block and gives the verdict.
module tb_tanh_rational_approximation;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 40;     // allow margin over the block's latency
  localparam int WATCHDOG = 5000;

  logic clk, rst, in_valid, in_stall, out_valid, out_stall;
  logic signed [tra_pkg::XW-1:0] x_in, tanh_out;
  int fail_count, pending, idle_cycles;
  logic [15:0] request_samples[$];

  tanh_rational_approximation dut (.*);
  tanh_rational_approximation_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Receiver: alternate between free-running stretches and random stalls.
  initial out_stall = 0;
  always @(posedge clk) begin
    int mode;
    mode = (int'($realtime) / 400) % 3;
    if (mode == 0) out_stall <= 0;
    else if (mode == 1) out_stall <= ($urandom_range(3) == 0);
    else out_stall <= ($urandom_range(1) == 0);
  end

  // Watchdog: count cycles with no handshake on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int burst, gap, i;
    logic [15:0] x;
    rst = 1; in_valid = 0; x_in = 0;
    // Directed: zero, extremes, exactly plus and minus four, just beyond four.
    request_samples = '{16'h0000, 16'h7fff, 16'h8000, 16'h4000, 16'hc000, 16'h4001,
      16'hbfff, 16'h3fff, 16'hc001, 16'h0001, 16'hffff, 16'h1000, 16'hf000,
      16'h0800, 16'hf800, 16'h5555, 16'haaaa, 16'h0002, 16'hfffe};
    // Random: mostly inside the rational range, some over the whole field.
    for (i = 0; i < 1050; i++) begin
      if ($urandom_range(3) == 0) x = 16'($urandom);
      else x = 16'($signed($urandom_range(32768)) - 16384);
      request_samples.push_back(x);
    end
    repeat (6) @(posedge clk);
    rst <= 0;
    while (request_samples.size() > 0) begin
      burst = $urandom_range(40, 1);
      while (burst > 0 && request_samples.size() > 0) begin
        // Hold the request until the block takes it.
        in_valid <= 1;
        x_in <= request_samples.pop_front();
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst--;
      end
      gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(6);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 0;
    @(posedge clk);
    while (pending > 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

// File: files.f
rtl/core/tra_pkg.sv
rtl/core/tra_poly.sv
rtl/core/tra_mac_cell.sv
rtl/core/tra_div_cell.sv
rtl/core/tanh_rational_approximation.sv
rtl/core/tra_checker.sv
dv/tanh_rational_approximation_checker.sv
dv/tb_tanh_rational_approximation.sv
